// ===== hdl/fprm_pkg.sv =====
// fprm_pkg: shared constants, request and register codes, divider control types
// for the frame pacer and rate monitor; no dependencies
package fprm_pkg;

  // history window
  localparam int HIST_LEN = 64;
  localparam int HEAD_W   = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int ENTRY_W  = 16;
  localparam int SUM_W    = $clog2(HIST_LEN * 65536);

  // rates and periods
  localparam int RATE_W     = 10;
  localparam int PER_W      = 10;
  localparam int TICK_W     = 10;
  localparam int STAMP_W    = 32;
  localparam int RATE_CAP   = 1000;
  localparam int RATE_RST   = 60;
  localparam int TICK_RST   = 16;
  localparam int PER_RST    = 1000 / RATE_RST;
  localparam int RATE_NUM   = HIST_LEN * 1000;
  localparam int RATE_NUM_W = $clog2(RATE_NUM + 1);
  localparam int SUM_RST    = RATE_NUM / RATE_RST;

  // shared divider
  localparam int DIV_W  = 32;
  localparam int ITER_W = $clog2(DIV_W + 1);
  localparam logic [DIV_W-1:0] PER_DVD  = DIV_W'(1000) << (DIV_W - PER_W);
  localparam logic [DIV_W-1:0] RATE_DVD = DIV_W'(RATE_NUM) << (DIV_W - RATE_NUM_W);

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRAW_RATE   = 2'd0,
    CFG_TICK_PERIOD = 2'd1,
    CFG_VSYNC_ON    = 2'd2,
    CFG_CREDIT_MODE = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_FRAME   = 2'd0,
    REQ_TICK    = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_RESTART = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CREDIT_ELAPSED = 2'd0,
    CREDIT_CAPPED  = 2'd1,
    CREDIT_FIXED   = 2'd2,
    CREDIT_SPARE   = 2'd3
  } credit_mode_t;

  // divider launch and status
  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/fprm_ram.sv =====
// fprm_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module fprm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/fprm_div.sv =====
// fprm_div: shared restoring divider, one quotient bit per cycle
// depends on fprm_pkg (widths, div_req_t, div_stat_t)
module fprm_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fprm_pkg::div_req_t             req,
  input  logic [fprm_pkg::DIV_W-1:0]     dividend,
  input  logic [fprm_pkg::DIV_W-1:0]     divisor,
  output fprm_pkg::div_stat_t            stat,
  output logic [fprm_pkg::DIV_W-1:0]     quotient,
  output logic [fprm_pkg::DIV_W-1:0]     remainder
);

  logic [fprm_pkg::DIV_W-1:0]  rem_r, rem_nxt;
  logic [fprm_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [fprm_pkg::DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [fprm_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [fprm_pkg::DIV_W:0]    shifted;
  logic [fprm_pkg::DIV_W:0]    diff;
  logic                        fits;

  // one trial subtraction per cycle
  assign shifted = {rem_r, quo_r[fprm_pkg::DIV_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[fprm_pkg::DIV_W-1:0] : shifted[fprm_pkg::DIV_W-1:0];
      quo_nxt = {quo_r[fprm_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == fprm_pkg::ITER_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // operands
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  // checks
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (divisor != '0))
    else $error("divider started with zero divisor");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

// ===== hdl/frame_pacer_rate_monitor.sv =====
// frame_pacer_rate_monitor: top level, sequencer, histories, credit and counters
// depends on fprm_pkg, fprm_div, fprm_ram
//
//  channel  dir  handshake               payload
//  in       in   in_valid / in_ready     in_req_type, in_now_ms, in_nth_divisor
//  out      out  out_valid / out_ready   out_tick_due, out_wait_ms, out_frame_rate,
//                                        out_frame_rate_max, out_tick_count, out_nth_hit
//  cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one word at a time; the shared divider sets the cost: a frame end runs the
// period (10 steps) and two window rates (16 steps each), a query 32 steps, a
// restart the period and one window sum; a tick request does not divide.
// reset is synchronous: histories read as the fill period via valid bits, so no
// clearing pass is needed and a restart clears them by dropping the valid bits.
// a finished word waits in the output register; the next word is accepted
// meanwhile and stalls at its last step until the output register frees.
module frame_pacer_rate_monitor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic [31:0]                         in_now_ms,
  input  logic [31:0]                         in_nth_divisor,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_tick_due,
  output logic [9:0]                          out_wait_ms,
  output logic [9:0]                          out_frame_rate,
  output logic [9:0]                          out_frame_rate_max,
  output logic [31:0]                         out_tick_count,
  output logic                                out_nth_hit,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fprm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fprm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int HL   = fprm_pkg::HIST_LEN;
  localparam int HW   = fprm_pkg::HEAD_W;
  localparam int EW   = fprm_pkg::ENTRY_W;
  localparam int SW   = fprm_pkg::SUM_W;
  localparam int RW   = fprm_pkg::RATE_W;
  localparam int PW   = fprm_pkg::PER_W;
  localparam int TW   = fprm_pkg::TICK_W;
  localparam int DW   = fprm_pkg::DIV_W;
  localparam int STW  = fprm_pkg::STAMP_W;

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_PER_WAIT   = 13'b0000000000010,
    S_RAW        = 13'b0000000000100,
    S_RAW_WAIT   = 13'b0000000001000,
    S_PACED      = 13'b0000000010000,
    S_PACED_PUSH = 13'b0000000100000,
    S_PACED_WAIT = 13'b0000001000000,
    S_FRAME_FIN  = 13'b0000010000000,
    S_TICK       = 13'b0000100000000,
    S_MOD_WAIT   = 13'b0001000000000,
    S_RST_WAIT1  = 13'b0010000000000,
    S_RST_WAIT2  = 13'b0100000000000,
    S_DONE       = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [RW-1:0] draw_rate_r;
  logic [TW-1:0] tick_period_r;
  logic          vsync_r;
  logic [1:0]    mode_r;

  // block state
  logic [STW-1:0] now_r, now_nxt;
  logic [STW-1:0] elapsed_r, elapsed_nxt;
  logic [STW-1:0] pe_r, pe_nxt;
  logic [PW-1:0]  p_r, p_nxt;
  logic [PW-1:0]  fill_r, fill_nxt;
  logic [SW-1:0]  raw_sum_r, raw_sum_nxt;
  logic [SW-1:0]  paced_sum_r, paced_sum_nxt;
  logic [RW-1:0]  rate_now_r, rate_now_nxt;
  logic [RW-1:0]  rate_best_r, rate_best_nxt;
  logic [31:0]    ticks_r, ticks_nxt;
  logic [STW-1:0] last_r, last_nxt;
  logic [31:0]    credit_r, credit_nxt;
  logic [HW-1:0]  head_r, head_nxt;
  logic [HL-1:0]  raw_vld_r, raw_vld_nxt;
  logic [HL-1:0]  paced_vld_r, paced_vld_nxt;

  // result of the word in flight
  logic           res_due_r, res_due_nxt;
  logic [9:0]     res_wait_r, res_wait_nxt;
  logic           res_hit_r, res_hit_nxt;

  // output register
  logic           out_valid_r, out_valid_nxt;
  logic           out_due_r, out_due_nxt;
  logic [9:0]     out_wait_r, out_wait_nxt;
  logic [RW-1:0]  out_rate_r, out_rate_nxt;
  logic [RW-1:0]  out_best_r, out_best_nxt;
  logic [31:0]    out_ticks_r, out_ticks_nxt;
  logic           out_hit_r, out_hit_nxt;

  // datapath
  logic [RW-1:0]  eff_rate;
  logic [EW-1:0]  raw_rdata, paced_rdata;
  logic [EW-1:0]  raw_old, paced_old, fill_entry;
  logic [EW-1:0]  raw_v, paced_v;
  logic [SW-1:0]  raw_sum_upd, paced_sum_upd;
  logic           raw_we, paced_we;
  logic           in_acc;
  logic           hold;
  logic [PW:0]    cap;
  logic [31:0]    credit_amt;
  logic [32:0]    credit_sum;

  fprm_pkg::div_req_t  div_req;
  fprm_pkg::div_stat_t div_stat;
  logic [DW-1:0]       div_dvd, div_dvs, div_q, div_rem;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_rate_r   <= RW'(fprm_pkg::RATE_RST);
      tick_period_r <= TW'(fprm_pkg::TICK_RST);
      vsync_r       <= 1'b0;
      mode_r        <= fprm_pkg::CREDIT_ELAPSED;
    end else if (cfg_valid && cfg_ready) begin
      case (fprm_pkg::cfg_idx_t'(cfg_index))
        fprm_pkg::CFG_DRAW_RATE:   draw_rate_r   <= cfg_data[RW-1:0];
        fprm_pkg::CFG_TICK_PERIOD: tick_period_r <= cfg_data[TW-1:0];
        fprm_pkg::CFG_VSYNC_ON:    vsync_r       <= cfg_data[0];
        fprm_pkg::CFG_CREDIT_MODE: mode_r        <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // effective draw rate, clamped to 1..1000
  always_comb begin
    if (draw_rate_r == '0) begin
      eff_rate = RW'(1);
    end else if (draw_rate_r > RW'(fprm_pkg::RATE_CAP)) begin
      eff_rate = RW'(fprm_pkg::RATE_CAP);
    end else begin
      eff_rate = draw_rate_r;
    end
  end

  // history memories, read at the head
  fprm_ram #(.WIDTH(EW), .DEPTH(HL)) u_raw_ram (
    .clk   (clk),
    .we    (raw_we),
    .waddr (head_r),
    .wdata (raw_v),
    .raddr (head_r),
    .rdata (raw_rdata)
  );

  fprm_ram #(.WIDTH(EW), .DEPTH(HL)) u_paced_ram (
    .clk   (clk),
    .we    (paced_we),
    .waddr (head_r),
    .wdata (paced_v),
    .raddr (head_r),
    .rdata (paced_rdata)
  );

  fprm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .stat      (div_stat),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // entries not written since the last fill read as the fill period
  assign fill_entry = {{(EW - PW){1'b0}}, fill_r};
  assign raw_old    = raw_vld_r[head_r]   ? raw_rdata   : fill_entry;
  assign paced_old  = paced_vld_r[head_r] ? paced_rdata : fill_entry;

  // saturated history entries and updated window sums
  assign raw_v   = (|elapsed_r[STW-1:EW]) ? {EW{1'b1}} : elapsed_r[EW-1:0];
  assign paced_v = (|pe_r[STW-1:EW])      ? {EW{1'b1}} : pe_r[EW-1:0];
  assign raw_sum_upd   = raw_sum_r - SW'(raw_old) + SW'(raw_v);
  assign paced_sum_upd = paced_sum_r - SW'(paced_old) + SW'(paced_v);

  assign raw_we   = (state_r == S_RAW) && (elapsed_r != '0);
  assign paced_we = (state_r == S_PACED_PUSH) && (pe_r != '0);

  // pacing hold and credit amount
  assign hold = !vsync_r && (elapsed_r < STW'(p_r));
  assign cap  = {p_r, 1'b0};
  always_comb begin
    case (fprm_pkg::credit_mode_t'(mode_r))
      fprm_pkg::CREDIT_CAPPED: credit_amt = (pe_r < 32'(cap)) ? pe_r : 32'(cap);
      default:                 credit_amt = pe_r;
    endcase
  end
  assign credit_sum = {1'b0, credit_r} + {1'b0, credit_amt};

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    elapsed_nxt   = elapsed_r;
    pe_nxt        = pe_r;
    p_nxt         = p_r;
    fill_nxt      = fill_r;
    raw_sum_nxt   = raw_sum_r;
    paced_sum_nxt = paced_sum_r;
    rate_now_nxt  = rate_now_r;
    rate_best_nxt = rate_best_r;
    ticks_nxt     = ticks_r;
    last_nxt      = last_r;
    credit_nxt    = credit_r;
    head_nxt      = head_r;
    raw_vld_nxt   = raw_vld_r;
    paced_vld_nxt = paced_vld_r;
    res_due_nxt   = res_due_r;
    res_wait_nxt  = res_wait_r;
    res_hit_nxt   = res_hit_r;
    out_valid_nxt = out_valid_r;
    out_due_nxt   = out_due_r;
    out_wait_nxt  = out_wait_r;
    out_rate_nxt  = out_rate_r;
    out_best_nxt  = out_best_r;
    out_ticks_nxt = out_ticks_r;
    out_hit_nxt   = out_hit_r;
    div_req.start = 1'b0;
    div_req.iters = fprm_pkg::ITER_W'(PW);
    div_dvd       = fprm_pkg::PER_DVD;
    div_dvs       = DW'(eff_rate);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_due_nxt  = 1'b0;
          res_wait_nxt = '0;
          res_hit_nxt  = 1'b0;
          now_nxt      = in_now_ms;
          elapsed_nxt  = in_now_ms - last_r;
          case (fprm_pkg::req_t'(in_req_type))
            fprm_pkg::REQ_FRAME: begin
              div_req.start = 1'b1;
              state_nxt     = S_PER_WAIT;
            end
            fprm_pkg::REQ_TICK: begin
              state_nxt = S_TICK;
            end
            fprm_pkg::REQ_QUERY: begin
              if (in_nth_divisor == '0) begin
                state_nxt = S_DONE;
              end else begin
                div_req.start = 1'b1;
                div_req.iters = fprm_pkg::ITER_W'(DW);
                div_dvd       = ticks_r;
                div_dvs       = in_nth_divisor;
                state_nxt     = S_MOD_WAIT;
              end
            end
            fprm_pkg::REQ_RESTART: begin
              div_req.start = 1'b1;
              state_nxt     = S_RST_WAIT1;
            end
            default: ;
          endcase
        end
      end

      // draw period for this frame
      S_PER_WAIT: begin
        if (div_stat.done) begin
          p_nxt     = div_q[PW-1:0];
          state_nxt = S_RAW;
        end
      end

      // unpaced history and best-case rate
      S_RAW: begin
        state_nxt = S_PACED;
        if (elapsed_r != '0) begin
          raw_sum_nxt         = raw_sum_upd;
          raw_vld_nxt[head_r] = 1'b1;
          if (raw_sum_upd < SW'(HL)) begin
            rate_best_nxt = RW'(fprm_pkg::RATE_CAP);
          end else begin
            div_req.start = 1'b1;
            div_req.iters = fprm_pkg::ITER_W'(fprm_pkg::RATE_NUM_W);
            div_dvd       = fprm_pkg::RATE_DVD;
            div_dvs       = DW'(raw_sum_upd);
            state_nxt     = S_RAW_WAIT;
          end
        end
      end

      S_RAW_WAIT: begin
        if (div_stat.done) begin
          rate_best_nxt = div_q[RW-1:0];
          state_nxt     = S_PACED;
        end
      end

      // hold a frame that came early
      S_PACED: begin
        if (hold) begin
          pe_nxt       = STW'(p_r);
          res_wait_nxt = p_r - elapsed_r[PW-1:0];
        end else begin
          pe_nxt = elapsed_r;
        end
        state_nxt = S_PACED_PUSH;
      end

      // paced history and frame rate
      S_PACED_PUSH: begin
        state_nxt = S_FRAME_FIN;
        if (pe_r != '0) begin
          paced_sum_nxt         = paced_sum_upd;
          paced_vld_nxt[head_r] = 1'b1;
          if (paced_sum_upd < SW'(HL)) begin
            rate_now_nxt = RW'(fprm_pkg::RATE_CAP);
          end else begin
            div_req.start = 1'b1;
            div_req.iters = fprm_pkg::ITER_W'(fprm_pkg::RATE_NUM_W);
            div_dvd       = fprm_pkg::RATE_DVD;
            div_dvs       = DW'(paced_sum_upd);
            state_nxt     = S_PACED_WAIT;
          end
        end
      end

      S_PACED_WAIT: begin
        if (div_stat.done) begin
          rate_now_nxt = div_q[RW-1:0];
          state_nxt    = S_FRAME_FIN;
        end
      end

      // advance head, stamp and tick credit
      S_FRAME_FIN: begin
        head_nxt = (head_r == HW'(HL - 1)) ? '0 : head_r + 1'b1;
        last_nxt = last_r + pe_r;
        if (fprm_pkg::credit_mode_t'(mode_r) == fprm_pkg::CREDIT_FIXED) begin
          credit_nxt = 32'(tick_period_r);
        end else if (credit_sum[32]) begin
          credit_nxt = '1;
        end else begin
          credit_nxt = credit_sum[31:0];
        end
        state_nxt = S_DONE;
      end

      // spend one tick period of credit
      S_TICK: begin
        if (credit_r >= 32'(tick_period_r)) begin
          credit_nxt  = credit_r - 32'(tick_period_r);
          ticks_nxt   = ticks_r + 1'b1;
          res_due_nxt = 1'b1;
        end
        state_nxt = S_DONE;
      end

      S_MOD_WAIT: begin
        if (div_stat.done) begin
          res_hit_nxt = (div_rem == '0);
          state_nxt   = S_DONE;
        end
      end

      // restart: period first, then the window sum
      S_RST_WAIT1: begin
        if (div_stat.done) begin
          p_nxt         = div_q[PW-1:0];
          div_req.start = 1'b1;
          div_req.iters = fprm_pkg::ITER_W'(fprm_pkg::RATE_NUM_W);
          div_dvd       = fprm_pkg::RATE_DVD;
          state_nxt     = S_RST_WAIT2;
        end
      end

      S_RST_WAIT2: begin
        if (div_stat.done) begin
          raw_sum_nxt   = div_q[SW-1:0];
          paced_sum_nxt = div_q[SW-1:0];
          rate_now_nxt  = eff_rate;
          rate_best_nxt = eff_rate;
          credit_nxt    = 32'(tick_period_r);
          last_nxt      = now_r;
          fill_nxt      = p_r;
          raw_vld_nxt   = '0;
          paced_vld_nxt = '0;
          state_nxt     = S_DONE;
        end
      end

      // hand the word to the output register
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_due_nxt   = res_due_r;
          out_wait_nxt  = res_wait_r;
          out_rate_nxt  = rate_now_r;
          out_best_nxt  = rate_best_r;
          out_ticks_nxt = ticks_r;
          out_hit_nxt   = res_hit_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= PW'(fprm_pkg::PER_RST);
      raw_sum_r   <= SW'(fprm_pkg::SUM_RST);
      paced_sum_r <= SW'(fprm_pkg::SUM_RST);
      rate_now_r  <= RW'(fprm_pkg::RATE_RST);
      rate_best_r <= RW'(fprm_pkg::RATE_RST);
      ticks_r     <= '0;
      last_r      <= '0;
      credit_r    <= 32'(fprm_pkg::TICK_RST);
      head_r      <= '0;
      raw_vld_r   <= '0;
      paced_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      raw_sum_r   <= raw_sum_nxt;
      paced_sum_r <= paced_sum_nxt;
      rate_now_r  <= rate_now_nxt;
      rate_best_r <= rate_best_nxt;
      ticks_r     <= ticks_nxt;
      last_r      <= last_nxt;
      credit_r    <= credit_nxt;
      head_r      <= head_nxt;
      raw_vld_r   <= raw_vld_nxt;
      paced_vld_r <= paced_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    elapsed_r   <= elapsed_nxt;
    pe_r        <= pe_nxt;
    p_r         <= p_nxt;
    res_due_r   <= res_due_nxt;
    res_wait_r  <= res_wait_nxt;
    res_hit_r   <= res_hit_nxt;
    out_due_r   <= out_due_nxt;
    out_wait_r  <= out_wait_nxt;
    out_rate_r  <= out_rate_nxt;
    out_best_r  <= out_best_nxt;
    out_ticks_r <= out_ticks_nxt;
    out_hit_r   <= out_hit_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_tick_due       = out_due_r;
  assign out_wait_ms        = out_wait_r;
  assign out_frame_rate     = out_rate_r;
  assign out_frame_rate_max = out_best_r;
  assign out_tick_count     = out_ticks_r;
  assign out_nth_hit        = out_hit_r;

  // checks
  a_rates_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (rate_now_r <= RW'(fprm_pkg::RATE_CAP)) && (rate_best_r <= RW'(fprm_pkg::RATE_CAP)))
    else $error("window rate above cap");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_PER_WAIT || state_r == S_RAW_WAIT ||
                       state_r == S_PACED_WAIT || state_r == S_MOD_WAIT ||
                       state_r == S_RST_WAIT1 || state_r == S_RST_WAIT2))
    else $error("divider result arrived outside a wait state");

  a_ticks_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(ticks_r) |-> ($past(state_r) == S_TICK))
    else $error("tick count changed outside a tick request");

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= HW'(HL - 1))
    else $error("ring head out of range");

endmodule
